// ===== design/rmh_pkg.sv =====
// rmh_pkg: shared types and sizing constants for the running median block
// depends on nothing; imported by every module in the design folder
package rmh_pkg;

    // heap geometry and sample format
    localparam int HALF_DEPTH   = 512;
    localparam int SAMPLE_WIDTH = 16;
    localparam int CNT_W        = $clog2(HALF_DEPTH + 1);
    localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic [CNT_W-1:0]               t_count;

    // operation broadcast to every cell of one chain
    typedef struct packed {
        logic insert;
        logic pop;
    } t_chain_op;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_INSERT = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_PUSH   = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

endpackage

// ===== design/running_median_two_heaps_top.sv =====
// running_median_two_heaps_top: lower median of all kept samples, two sorted cell chains
// depends on rmh_pkg, rmh_chain and rmh_cell
//
// channel   direction  handshake              payload
// s_axis    in         i_s_tvalid/o_s_tready   tdata[15:0] sample
// m_axis    out        o_m_tvalid/i_m_tready   tdata[15:0] median, tuser[0] dropped
//
// an item goes from acceptance through insert, root check with pop, re-insert when the
// roots are exchanged, and result load before the next acceptance; a dropped sample
// goes from acceptance straight to result load
// reset is synchronous and clears counts, parity and handshake state; no clearing pass
// a stalled output holds in its register while the next sample is accepted and worked;
// the sequencer waits in its last state only while that register is still full
module running_median_two_heaps_top import rmh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [TDATA_W-1:0] i_s_tdata,   // [15:0] sample
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,   // [15:0] median, rest zero
    output logic               o_m_tuser    // [0] dropped
);

    t_state    r_state;
    t_state    n_state;
    t_count    r_lcnt;
    t_count    n_lcnt;
    t_count    r_ucnt;
    t_count    n_ucnt;
    logic      r_parity;
    logic      n_parity;
    t_sample   r_sample;
    logic      r_drop;
    t_sample   r_low_root;
    t_sample   r_up_root;
    logic      r_out_valid;
    t_sample   r_median;
    logic      r_out_drop;

    t_sample   w_low_root;
    t_sample   w_up_root;
    logic      w_full;
    logic      w_swap;
    logic      w_accept;
    logic      w_load;
    t_chain_op w_low_op;
    t_chain_op w_up_op;
    t_sample   w_low_value;
    t_sample   w_up_value;

    // lower half keeps the largest at its root, upper half the smallest
    rmh_chain u_lower (
        .i_clk       (i_clk),
        .i_op        (w_low_op),
        .i_order_max (1'b1),
        .i_count     (r_lcnt),
        .i_value     (w_low_value),
        .o_root      (w_low_root)
    );

    rmh_chain u_upper (
        .i_clk       (i_clk),
        .i_op        (w_up_op),
        .i_order_max (1'b0),
        .i_count     (r_ucnt),
        .i_value     (w_up_value),
        .o_root      (w_up_root)
    );

    // status and handshake terms
    assign w_full     = (r_lcnt == CNT_W'(HALF_DEPTH)) && (r_ucnt == CNT_W'(HALF_DEPTH));
    assign w_swap     = (r_lcnt != '0) && (r_ucnt != '0) && (w_up_root < w_low_root);
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = (r_state == ST_DONE) && (!r_out_valid || i_m_tready);

    // chain operations for each state
    always_comb begin
        w_low_op.insert = ((r_state == ST_INSERT) && !r_parity) || (r_state == ST_PUSH);
        w_low_op.pop    = (r_state == ST_CHECK) && w_swap;
        w_up_op.insert  = ((r_state == ST_INSERT) && r_parity) || (r_state == ST_PUSH);
        w_up_op.pop     = (r_state == ST_CHECK) && w_swap;
        w_low_value     = (r_state == ST_INSERT) ? r_sample : r_up_root;
        w_up_value      = (r_state == ST_INSERT) ? r_sample : r_low_root;
    end

    // sequencer and count bookkeeping
    always_comb begin
        n_state  = r_state;
        n_lcnt   = r_lcnt;
        n_ucnt   = r_ucnt;
        n_parity = r_parity;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_full ? ST_DONE : ST_INSERT;
                end
            end
            ST_INSERT: begin
                if (r_parity) begin
                    n_ucnt = r_ucnt + CNT_W'(1);
                end else begin
                    n_lcnt = r_lcnt + CNT_W'(1);
                end
                n_parity = !r_parity;
                n_state  = ST_CHECK;
            end
            ST_CHECK: begin
                if (w_swap) begin
                    n_lcnt  = r_lcnt - CNT_W'(1);
                    n_ucnt  = r_ucnt - CNT_W'(1);
                    n_state = ST_PUSH;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_PUSH: begin
                n_lcnt  = r_lcnt + CNT_W'(1);
                n_ucnt  = r_ucnt + CNT_W'(1);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lcnt      <= '0;
            r_ucnt      <= '0;
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_lcnt   <= n_lcnt;
            r_ucnt   <= n_ucnt;
            r_parity <= n_parity;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_s_tdata[SAMPLE_WIDTH-1:0];
            r_drop   <= w_full;
        end
        if ((r_state == ST_CHECK) && w_swap) begin
            r_low_root <= w_low_root;
            r_up_root  <= w_up_root;
        end
        if (w_load) begin
            r_median   <= (r_lcnt != '0) ? w_low_root : '0;
            r_out_drop <= r_drop;
        end
    end

    // output transaction
    always_comb begin
        o_m_tdata                   = '0;
        o_m_tdata[SAMPLE_WIDTH-1:0] = r_median;
    end
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_drop;

    // halves stay balanced and parity tracks which one is ahead
    a_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lcnt == r_ucnt) || (r_lcnt == r_ucnt + CNT_W'(1)))
        else $error("heap halves out of balance");

    a_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_parity == (r_lcnt != r_ucnt))
        else $error("parity does not match heap counts");

    // between items every lower sample is at or below every upper sample
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) && (r_lcnt != '0) && (r_ucnt != '0)) |->
        !(w_up_root < w_low_root))
        else $error("upper root below lower root while idle");

    // an accepted sample is either inserted or reported as dropped next
    a_accept_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ((r_state == ST_INSERT) || ((r_state == ST_DONE) && r_drop)))
        else $error("accepted sample took no valid path");

endmodule

// ===== design/rmh_cell.sv =====
// rmh_cell: one slot of a sorted priority chain, holds one sample
// depends on rmh_pkg; instantiated by rmh_chain
module rmh_cell import rmh_pkg::*; (
    input  logic      i_clk,
    input  t_chain_op i_op,
    input  logic      i_order_max,
    input  logic      i_occupied,
    input  t_sample   i_value,
    input  t_sample   i_prev_value,
    input  logic      i_prev_keep,
    input  t_sample   i_next_value,
    output t_sample   o_value,
    output logic      o_keep
);

    t_sample r_value;
    t_sample n_value;
    logic    w_keep;

    // slot keeps its sample when it is in use and ranks at or above the new one
    assign w_keep = i_occupied && (i_order_max ? !(i_value > r_value) : !(i_value < r_value));

    // insert shifts away from the root, pop shifts toward it
    always_comb begin
        n_value = r_value;
        if (i_op.insert) begin
            if (w_keep) begin
                n_value = r_value;
            end else if (i_prev_keep) begin
                n_value = i_value;
            end else begin
                n_value = i_prev_value;
            end
        end else if (i_op.pop) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_keep  = w_keep;

endmodule

// ===== design/rmh_chain.sv =====
// rmh_chain: row of HALF_DEPTH cells kept sorted, root at cell zero
// depends on rmh_pkg and rmh_cell; instantiated twice by the top level
module rmh_chain import rmh_pkg::*; (
    input  logic      i_clk,
    input  t_chain_op i_op,
    input  logic      i_order_max,
    input  t_count    i_count,
    input  t_sample   i_value,
    output t_sample   o_root
);

    t_sample w_value [HALF_DEPTH];
    logic    w_keep  [HALF_DEPTH];

    // each cell talks only to its two neighbors
    for (genvar g = 0; g < HALF_DEPTH; g++) begin : g_cell
        t_sample w_prev_value;
        logic    w_prev_keep;
        t_sample w_next_value;

        // the root has nothing above it, so it takes the new sample when it yields
        if (g == 0) begin : g_head
            assign w_prev_value = w_value[g];
            assign w_prev_keep  = 1'b1;
        end else begin : g_body
            assign w_prev_value = w_value[g-1];
            assign w_prev_keep  = w_keep[g-1];
        end

        if (g == HALF_DEPTH - 1) begin : g_tail
            assign w_next_value = w_value[g];
        end else begin : g_inner
            assign w_next_value = w_value[g+1];
        end

        rmh_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (i_op),
            .i_order_max  (i_order_max),
            .i_occupied   (i_count > CNT_W'(g)),
            .i_value      (i_value),
            .i_prev_value (w_prev_value),
            .i_prev_keep  (w_prev_keep),
            .i_next_value (w_next_value),
            .o_value      (w_value[g]),
            .o_keep       (w_keep[g])
        );
    end

    assign o_root = w_value[0];

endmodule
